[rtl/core/grc_pkg.sv]
// ----------------------------------------------------------------------------
// grc_pkg: shared types and constants
// Status codes, geometry limits, command and status structs for the
// rectangle cover unit.
// ----------------------------------------------------------------------------
package grc_pkg;

	localparam int MAX_WIDTH  = 64;
	localparam int MAX_HEIGHT = 64;
	localparam int MAX_KEYS   = 16;
	localparam int CELLS      = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW         = $clog2(CELLS);
	localparam int CW         = $clog2(CELLS + 1);
	localparam int XW         = $clog2(MAX_WIDTH + 1);
	localparam int YW         = $clog2(MAX_HEIGHT + 1);

	localparam logic [1:0] KIND_LOAD  = 2'd0;
	localparam logic [1:0] KIND_FETCH = 2'd1;
	localparam logic [1:0] KIND_START = 2'd2;

	localparam logic [1:0] ST_RECT       = 2'd0;
	localparam logic [1:0] ST_DONE       = 2'd1;
	localparam logic [1:0] ST_UNKNOWN    = 2'd2;
	localparam logic [1:0] ST_INCOMPLETE = 2'd3;

	localparam logic [2:0] REG_WIDTH     = 3'd0;
	localparam logic [2:0] REG_HEIGHT    = 3'd1;
	localparam logic [2:0] REG_KEY_COUNT = 3'd2;
	localparam logic [2:0] REG_KEYS_LOW  = 3'd3;
	localparam logic [2:0] REG_KEYS_HIGH = 3'd4;
	localparam logic [2:0] REG_BLANK     = 3'd5;

	// datapath operations requested by the controller
	typedef enum logic [3:0] {
		OP_NONE,
		OP_CLEAR,      // clear covered entry at clr counter
		OP_ALIGN_SET,  // reload raster position from scan position
		OP_ALIGN_STEP, // take one row off the raster position
		OP_SEED_RD,    // issue reads at scan position
		OP_SEED_CHK,   // evaluate seed
		OP_RUN_RD,     // read cell right of run
		OP_RUN_CHK,
		OP_ROW_RD,     // read cell in candidate row
		OP_ROW_CHK,
		OP_MARK_SET,   // rewind to the top left cell for marking
		OP_MARK        // mark one cell of rectangle covered
	} op_t;

	typedef struct packed {
		op_t op;
	} cmd_t;

	typedef struct packed {
		logic clear_last;   // clearing sweep at last entry
		logic scan_end;     // scan position reached total
		logic misaligned;   // raster position built for another width
		logic align_more;   // raster column still past the row
		logic seed_skip;    // seed covered or blank
		logic run_in;       // cell right of run lies inside the row
		logic same;         // probed cell free and of the seed's index
		logic row_can;      // another row exists below
		logic mark_last;    // last cell of rectangle
	} stat_t;

endpackage

[rtl/core/grc_ram.sv]
// ----------------------------------------------------------------------------
// grc_ram: generic single-port-write, single-read RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module grc_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule

[rtl/core/grc_datapath.sv]
// ----------------------------------------------------------------------------
// grc_datapath: grid stores, scan counters and rectangle growth
// Holds index and covered memories, key lookup and the seed/run/row walk.
// ----------------------------------------------------------------------------
module grc_datapath
	import grc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cmd_t        cmd,
	output stat_t       stat,
	input  logic        load_en,
	input  logic        start_en,
	input  logic [7:0]  cell_char,
	input  logic [6:0]  grid_width,
	input  logic [6:0]  grid_height,
	input  logic [4:0]  key_count,
	input  logic [63:0] key_chars_low,
	input  logic [63:0] key_chars_high,
	input  logic [15:0] blank_mask,
	output logic        full,
	output logic        unknown,
	output logic [5:0]  rect_x,
	output logic [5:0]  rect_y,
	output logic [6:0]  rect_w,
	output logic [6:0]  rect_h,
	output logic [3:0]  colour_index
);
	// clamped geometry
	logic [XW-1:0] w_eff;
	logic [YW-1:0] h_eff;
	logic [CW-1:0] total;
	always_comb begin
		if (grid_width == 7'd0) w_eff = XW'(1);
		else if (32'(grid_width) > MAX_WIDTH) w_eff = XW'(MAX_WIDTH);
		else w_eff = XW'(grid_width);
		if (grid_height == 7'd0) h_eff = YW'(1);
		else if (32'(grid_height) > MAX_HEIGHT) h_eff = YW'(MAX_HEIGHT);
		else h_eff = YW'(grid_height);
		total = CW'(w_eff) * CW'(h_eff);
	end

	// key lookup: lowest matching index wins
	logic [4:0]   n_keys;
	logic [3:0]   key_idx;
	logic         key_hit;
	logic [127:0] keys;
	always_comb begin
		n_keys = (key_count > 5'(MAX_KEYS)) ? 5'(MAX_KEYS) : key_count;
		keys = {key_chars_high, key_chars_low};
		key_idx = '0;
		key_hit = 1'b0;
		for (int i = 15; i >= 0; i--) begin
			if (5'(i) < n_keys && keys[i*8 +: 8] == cell_char) begin
				key_idx = 4'(i);
				key_hit = 1'b1;
			end
		end
	end

	logic [CW-1:0] loaded_q;
	logic          unknown_q;
	logic          load_ok;
	assign load_ok = load_en && loaded_q < total;
	assign full    = loaded_q >= total;
	assign unknown = unknown_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q  <= '0;
			unknown_q <= 1'b0;
		end else if (start_en) begin
			loaded_q  <= '0;
			unknown_q <= 1'b0;
		end else if (load_ok) begin
			loaded_q <= loaded_q + CW'(1);
			if (!key_hit) unknown_q <= 1'b1;
		end
	end

	// scan and walk registers
	logic [CW-1:0] scan_q, sx_q;
	logic [YW-1:0] sy_q;
	logic [XW-1:0] w_used_q;
	logic [AW-1:0] clr_q, seed_q, row_q;
	logic [XW-1:0] x_q, rw_q, k_q;
	logic [YW-1:0] y_q, rh_q, j_q;
	logic [3:0]    idx_q;

	logic [AW-1:0] raddr;
	logic [3:0]    idx_rd;
	logic          cov_rd;
	logic          cov_we;
	logic [AW-1:0] cov_waddr;
	logic          cov_wdata;

	// one read address serves both memories
	always_comb begin
		case (cmd.op)
			OP_SEED_RD: raddr = scan_q[AW-1:0];
			OP_RUN_RD:  raddr = seed_q + AW'(rw_q);
			default:    raddr = row_q + AW'(k_q);
		endcase
	end

	grc_ram #(.WIDTH(4), .DEPTH(CELLS)) u_idx (
		.clk(clk), .we(load_ok), .waddr(loaded_q[AW-1:0]),
		.wdata(key_idx), .raddr(raddr), .rdata(idx_rd)
	);

	always_comb begin
		cov_we    = 1'b0;
		cov_waddr = row_q + AW'(k_q);
		cov_wdata = 1'b1;
		case (cmd.op)
			OP_CLEAR: begin
				cov_we = 1'b1; cov_waddr = clr_q; cov_wdata = 1'b0;
			end
			OP_SEED_CHK: begin
				cov_we = 1'b1; cov_waddr = seed_q;
			end
			OP_MARK: cov_we = 1'b1;
			default: ;
		endcase
	end

	grc_ram #(.WIDTH(1), .DEPTH(CELLS)) u_cov (
		.clk(clk), .we(cov_we), .waddr(cov_waddr), .wdata(cov_wdata),
		.raddr(raddr), .rdata(cov_rd)
	);

	logic same;
	assign same = !cov_rd && idx_rd == idx_q;

	always_comb begin
		stat.clear_last = clr_q == AW'(CELLS - 1);
		stat.scan_end   = scan_q >= total;
		stat.misaligned = w_used_q != w_eff;
		stat.align_more = sx_q >= CW'(w_eff);
		stat.seed_skip  = cov_rd || blank_mask[idx_rd];
		stat.run_in     = (XW+1)'(x_q) + (XW+1)'(rw_q) < (XW+1)'(w_eff);
		stat.same       = same;
		stat.row_can    = (YW+1)'(y_q) + (YW+1)'(rh_q) < (YW+1)'(h_eff);
		stat.mark_last  = k_q == rw_q - XW'(1) && j_q == rh_q - YW'(1);
	end

	// scan position and its raster column and row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q   <= '0;
			sx_q     <= '0;
			sy_q     <= '0;
			w_used_q <= XW'(1);
			clr_q    <= '0;
		end else if (start_en) begin
			scan_q   <= '0;
			sx_q     <= '0;
			sy_q     <= '0;
			w_used_q <= w_eff;
		end else begin
			case (cmd.op)
				OP_CLEAR: clr_q <= stat.clear_last ? '0 : clr_q + AW'(1);
				OP_ALIGN_SET: begin
					sx_q     <= scan_q;
					sy_q     <= '0;
					w_used_q <= w_eff;
				end
				OP_ALIGN_STEP: begin
					sx_q <= sx_q - CW'(w_eff);
					sy_q <= sy_q + YW'(1);
				end
				OP_SEED_RD: begin
					scan_q <= scan_q + CW'(1);
					if (sx_q + CW'(1) >= CW'(w_eff)) begin
						sx_q <= '0;
						sy_q <= sy_q + YW'(1);
					end else begin
						sx_q <= sx_q + CW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	// row_q holds the linear address of the row being probed or marked
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q <= '0;
			row_q  <= '0;
			x_q    <= '0;
			y_q    <= '0;
			rw_q   <= '0;
			rh_q   <= '0;
			k_q    <= '0;
			j_q    <= '0;
			idx_q  <= '0;
		end else begin
			case (cmd.op)
				OP_SEED_RD: begin
					seed_q <= scan_q[AW-1:0];
					x_q    <= sx_q[XW-1:0];
					y_q    <= sy_q;
				end
				OP_SEED_CHK: begin
					idx_q <= idx_rd;
					rw_q  <= XW'(1);
					rh_q  <= YW'(1);
					k_q   <= '0;
					row_q <= seed_q + AW'(w_eff);
				end
				OP_RUN_CHK: begin
					if (same) rw_q <= rw_q + XW'(1);
				end
				OP_ROW_CHK: begin
					if (k_q == rw_q - XW'(1)) begin
						rh_q  <= rh_q + YW'(1);
						k_q   <= '0;
						row_q <= row_q + AW'(w_eff);
					end else begin
						k_q <= k_q + XW'(1);
					end
				end
				OP_MARK_SET: begin
					row_q <= seed_q;
					k_q   <= '0;
					j_q   <= '0;
				end
				OP_MARK: begin
					if (k_q == rw_q - XW'(1)) begin
						k_q   <= '0;
						j_q   <= j_q + YW'(1);
						row_q <= row_q + AW'(w_eff);
					end else begin
						k_q <= k_q + XW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	assign rect_x       = x_q[5:0];
	assign rect_y       = y_q[5:0];
	assign rect_w       = rw_q;
	assign rect_h       = rh_q;
	assign colour_index = idx_q;
endmodule

[rtl/core/grc_ctrl.sv]
// ----------------------------------------------------------------------------
// grc_ctrl: command sequencer
// Accepts items, runs clearing sweep and the fetch walk, issues the result.
// ----------------------------------------------------------------------------
module grc_ctrl
	import grc_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	input  logic [1:0] kind,
	output logic       busy,
	output logic       load_en,
	output logic       start_en,
	output cmd_t       cmd,
	input  stat_t      stat,
	input  logic       full,
	input  logic       unknown,
	output logic       done,
	output logic [1:0] status
);
	localparam logic [3:0] S_CLEAR   = 4'd0;
	localparam logic [3:0] S_IDLE    = 4'd1;
	localparam logic [3:0] S_SEED_RD = 4'd2;
	localparam logic [3:0] S_SEED    = 4'd3;
	localparam logic [3:0] S_RUN_RD  = 4'd4;
	localparam logic [3:0] S_RUN     = 4'd5;
	localparam logic [3:0] S_ROW_RD  = 4'd6;
	localparam logic [3:0] S_ROW     = 4'd7;
	localparam logic [3:0] S_MARK    = 4'd8;
	localparam logic [3:0] S_ALIGN   = 4'd9;

	logic [3:0] state_q, state_d;
	logic       acc;

	assign busy     = state_q != S_IDLE;
	assign acc      = start && !busy;
	assign load_en  = acc && kind == KIND_LOAD;
	assign start_en = acc && kind == KIND_START;

	always_comb begin
		state_d = state_q;
		cmd.op  = OP_NONE;
		done    = 1'b0;
		status  = ST_RECT;
		unique case (state_q)
			S_CLEAR: begin
				cmd.op = OP_CLEAR;
				if (stat.clear_last) state_d = S_IDLE;
			end
			S_IDLE: begin
				if (acc && kind == KIND_START) begin
					state_d = S_CLEAR;
				end else if (acc && kind == KIND_FETCH) begin
					if (!full) begin
						done = 1'b1; status = ST_INCOMPLETE;
					end else if (unknown) begin
						done = 1'b1; status = ST_UNKNOWN;
					end else begin
						state_d = S_SEED_RD;
					end
				end
			end
			S_SEED_RD: begin
				if (stat.scan_end) begin
					done = 1'b1; status = ST_DONE; state_d = S_IDLE;
				end else if (stat.misaligned) begin
					cmd.op = OP_ALIGN_SET; state_d = S_ALIGN;
				end else begin
					cmd.op = OP_SEED_RD; state_d = S_SEED;
				end
			end
			S_ALIGN: begin
				if (stat.align_more) cmd.op = OP_ALIGN_STEP;
				else state_d = S_SEED_RD;
			end
			S_SEED: begin
				cmd.op = OP_SEED_CHK;
				state_d = stat.seed_skip ? S_SEED_RD : S_RUN_RD;
			end
			S_RUN_RD: begin
				if (stat.run_in) begin
					cmd.op = OP_RUN_RD; state_d = S_RUN;
				end else begin
					state_d = S_ROW_RD;
				end
			end
			S_RUN: begin
				cmd.op = OP_RUN_CHK;
				state_d = stat.same ? S_RUN_RD : S_ROW_RD;
			end
			S_ROW_RD: begin
				if (stat.row_can) begin
					cmd.op = OP_ROW_RD; state_d = S_ROW;
				end else begin
					cmd.op = OP_MARK_SET; state_d = S_MARK;
				end
			end
			S_ROW: begin
				if (stat.same) begin
					cmd.op = OP_ROW_CHK; state_d = S_ROW_RD;
				end else begin
					cmd.op = OP_MARK_SET; state_d = S_MARK;
				end
			end
			S_MARK: begin
				cmd.op = OP_MARK;
				if (stat.mark_last) begin
					done = 1'b1; status = ST_RECT; state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_CLEAR;
		else state_q <= state_d;
	end
endmodule

[rtl/core/greedy_rectangle_cover_unit.sv]
// ----------------------------------------------------------------------------
// greedy_rectangle_cover_unit: greedy rectangle cover of a character grid
// Loads a palette-mapped grid and hands out covering rectangles on fetch.
// ----------------------------------------------------------------------------
// Words are taken while busy is low. A start, and reset, run a sweep over
// all MAX_WIDTH*MAX_HEIGHT entries of the covered map, during which busy is
// high. A fetch on an incomplete grid or one holding an unknown character
// answers in the cycle it is taken. Otherwise it leaves idle and visits
// seeds in raster order; for each seed that is neither covered nor blank it
// probes cells along the run and then in the rows below, and marks each cell
// of the rectangle covered. Every seed and probed cell takes a read step and
// a check step, since the two memories share one read port. If the width
// changed in mid-scan, the raster position is first rebuilt row by row. The
// result is on the ports with done for one cycle only and must be taken
// then: the receiver cannot stall it.
module greedy_rectangle_cover_unit
	import grc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  kind,
	input  logic [7:0]  cell_char,
	output logic        done,
	output logic [1:0]  status,
	output logic [5:0]  rect_x,
	output logic [5:0]  rect_y,
	output logic [6:0]  rect_w,
	output logic [6:0]  rect_h,
	output logic [3:0]  colour_index,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data
);
	logic [6:0]  w_q, h_q;
	logic [4:0]  kc_q;
	logic [63:0] kl_q, kh_q;
	logic [15:0] bm_q;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q <= 7'd1; h_q <= 7'd1; kc_q <= '0;
			kl_q <= '0; kh_q <= '0; bm_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_WIDTH:     w_q  <= cfg_data[6:0];
				REG_HEIGHT:    h_q  <= cfg_data[6:0];
				REG_KEY_COUNT: kc_q <= cfg_data[4:0];
				REG_KEYS_LOW:  kl_q <= cfg_data;
				REG_KEYS_HIGH: kh_q <= cfg_data;
				REG_BLANK:     bm_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	cmd_t  cmd;
	stat_t stat;
	logic  load_en, start_en, full, unknown;
	logic  done_c;
	logic [1:0] status_c;
	logic [5:0] dx, dy;
	logic [6:0] dw, dh;
	logic [3:0] dc;

	grc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .kind(kind), .busy(busy),
		.load_en(load_en), .start_en(start_en), .cmd(cmd), .stat(stat),
		.full(full), .unknown(unknown), .done(done_c), .status(status_c)
	);

	grc_datapath u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .stat(stat),
		.load_en(load_en), .start_en(start_en), .cell_char(cell_char),
		.grid_width(w_q), .grid_height(h_q), .key_count(kc_q),
		.key_chars_low(kl_q), .key_chars_high(kh_q), .blank_mask(bm_q),
		.full(full), .unknown(unknown), .rect_x(dx), .rect_y(dy),
		.rect_w(dw), .rect_h(dh), .colour_index(dc)
	);

	logic is_rect;
	assign is_rect      = status_c == ST_RECT;
	assign done         = done_c;
	assign status       = status_c;
	assign rect_x       = is_rect ? dx : 6'd0;
	assign rect_y       = is_rect ? dy : 6'd0;
	assign rect_w       = is_rect ? dw : 7'd0;
	assign rect_h       = is_rect ? dh : 7'd0;
	assign colour_index = is_rect ? dc : 4'd0;
endmodule

[tb/grc_cover_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grc_cover_checker: prediction and checking for the rectangle cover unit
// Watches the command, result and register channels, keeps its own copy of
// the palette grid and covered map, and compares every result word with the
// oldest expected one.
// ----------------------------------------------------------------------------
module grc_cover_checker
	import grc_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [1:0]  kind,
	input  logic [7:0]  cell_char,
	input  logic        done,
	input  logic [1:0]  status,
	input  logic [5:0]  rect_x,
	input  logic [5:0]  rect_y,
	input  logic [6:0]  rect_w,
	input  logic [6:0]  rect_h,
	input  logic [3:0]  colour_index,
	input  logic        cfg_valid,
	input  logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [63:0] cfg_data,
	output int          errors,
	output int          pending
);

	localparam int GRID_CELLS = 64 * 64;

	typedef struct packed {
		logic [1:0] st;
		logic [5:0] x;
		logic [5:0] y;
		logic [6:0] w;
		logic [6:0] h;
		logic [3:0] ci;
	} rect_word_t;

	rect_word_t rect_expect_q[$];

	logic [6:0]  width_reg, height_reg;
	logic [4:0]  key_count_reg;
	logic [63:0] keys_low_reg, keys_high_reg;
	logic [15:0] blank_reg;

	logic [3:0]  palette_grid[GRID_CELLS];
	bit          covered[GRID_CELLS];
	int          loaded;
	int          scan_at;
	bit          unknown_flag;

	function automatic int grid_w();
		if (width_reg == 0) return 1;
		if (width_reg > 64) return 64;
		return width_reg;
	endfunction

	function automatic int grid_h();
		if (height_reg == 0) return 1;
		if (height_reg > 64) return 64;
		return height_reg;
	endfunction

	// first matching key wins; -1 when none matches
	function automatic int palette_of(logic [7:0] ch);
		int n;
		logic [7:0] k;
		n = (key_count_reg > 16) ? 16 : key_count_reg;
		for (int i = 0; i < n; i++) begin
			k = (i < 8) ? keys_low_reg[i*8 +: 8] : keys_high_reg[(i-8)*8 +: 8];
			if (k == ch) return i;
		end
		return -1;
	endfunction

	function automatic bit free_same(int at, logic [3:0] idx);
		return at < GRID_CELLS && !covered[at] && palette_grid[at] == idx;
	endfunction

	function automatic rect_word_t cover_next_rect();
		rect_word_t r;
		int w, h, total, seed, x, y, rw, rh;
		logic [3:0] idx;
		bit whole;
		r = '0;
		w = grid_w();
		h = grid_h();
		total = w * h;
		if (loaded < total) begin
			r.st = ST_INCOMPLETE;
			return r;
		end
		if (unknown_flag) begin
			r.st = ST_UNKNOWN;
			return r;
		end
		while (scan_at < total) begin
			seed = scan_at;
			x = seed % w;
			y = seed / w;
			scan_at++;
			if (covered[seed]) continue;
			idx = palette_grid[seed];
			covered[seed] = 1;
			if (blank_reg[idx]) continue;
			rw = 1;
			rh = 1;
			while (x + rw < w && free_same(seed + rw, idx)) rw++;
			whole = 1;
			while (whole && y + rh < h) begin
				for (int k = 0; k < rw; k++)
					if (!free_same((y + rh) * w + x + k, idx)) whole = 0;
				if (whole) rh++;
			end
			for (int j = 0; j < rh; j++)
				for (int k = 0; k < rw; k++)
					covered[(y + j) * w + x + k] = 1;
			r.st = ST_RECT;
			r.x = 6'(x);
			r.y = 6'(y);
			r.w = 7'(rw);
			r.h = 7'(rh);
			r.ci = idx;
			return r;
		end
		r.st = ST_DONE;
		return r;
	endfunction

	task automatic note_fail(string what);
		errors++;
		if (errors <= 10) $display("%0t: %s", $realtime, what);
	endtask

	always @(posedge clk or negedge arst_n) begin
		rect_word_t want, got;
		int c;
		if (!arst_n) begin
			width_reg = 1;
			height_reg = 1;
			key_count_reg = 0;
			keys_low_reg = '0;
			keys_high_reg = '0;
			blank_reg = '0;
			for (int i = 0; i < GRID_CELLS; i++) begin
				palette_grid[i] = '0;
				covered[i] = 0;
			end
			loaded = 0;
			scan_at = 0;
			unknown_flag = 0;
			rect_expect_q.delete();
			errors = 0;
			pending = 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_WIDTH:     width_reg = cfg_data[6:0];
					REG_HEIGHT:    height_reg = cfg_data[6:0];
					REG_KEY_COUNT: key_count_reg = cfg_data[4:0];
					REG_KEYS_LOW:  keys_low_reg = cfg_data;
					REG_KEYS_HIGH: keys_high_reg = cfg_data;
					REG_BLANK:     blank_reg = cfg_data[15:0];
					default: ;
				endcase
			end
			// a fetch may answer in the cycle it is taken: predict before checking
			if (start && !busy) begin
				case (kind)
					KIND_LOAD: begin
						if (loaded < grid_w() * grid_h()) begin
							c = palette_of(cell_char);
							if (c < 0) begin
								unknown_flag = 1;
								c = 0;
							end
							palette_grid[loaded] = 4'(c);
							loaded++;
						end
					end
					KIND_START: begin
						for (int i = 0; i < GRID_CELLS; i++) covered[i] = 0;
						loaded = 0;
						scan_at = 0;
						unknown_flag = 0;
					end
					KIND_FETCH: begin
						want = cover_next_rect();
						rect_expect_q = {rect_expect_q, want};
					end
					default: ;
				endcase
			end
			if (done) begin
				got = '{status, rect_x, rect_y, rect_w, rect_h, colour_index};
				if (rect_expect_q.size() == 0) begin
					note_fail($sformatf("result word with nothing expected: %p", got));
				end else begin
					want = rect_expect_q.pop_front();
					if (got != want)
						note_fail($sformatf("result mismatch: expected %p, got %p", want, got));
				end
			end
			pending = rect_expect_q.size();
		end
	end

endmodule

[tb/greedy_rectangle_cover_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// greedy_rectangle_cover_unit_tb: stimulus and verdict for the cover unit
// Loads blocky grids of many sizes and palettes, fetches their rectangles
// under bursty command traffic, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module greedy_rectangle_cover_unit_tb
	import grc_pkg::*;
();

	localparam logic [1:0] KIND_NOP = 2'd3;
	localparam int IDLE_LIMIT = 60000;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        start = 0;
	logic [1:0]  kind = KIND_LOAD;
	logic [7:0]  cell_char = '0;
	logic        cfg_valid = 0;
	logic [2:0]  cfg_index = REG_WIDTH;
	logic [63:0] cfg_data = '0;
	logic        busy, done, cfg_ready;
	logic [1:0]  status;
	logic [5:0]  rect_x, rect_y;
	logic [6:0]  rect_w, rect_h;
	logic [3:0]  colour_index;
	int          errors, pending;

	int          burst_left = 0;
	int          words_sent = 0;
	int          idle_cycles = 0;
	int          eff_w = 1, eff_h = 1, eff_keys = 0;
	logic [7:0]  key_byte[16];

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	greedy_rectangle_cover_unit uut (.*);

	grc_cover_checker u_checker (.*);

	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("Test completed with failures");
			$finish;
		end
	end

	// hold start high across a burst; drop it only when the burst runs out
	task automatic put_word(input logic [1:0] k, input logic [7:0] ch);
		if (burst_left == 0) begin
			start <= 0;
			repeat ($urandom_range(0, 9) == 0 ? $urandom_range(10, 40) : $urandom_range(1, 5))
				@(negedge clk);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 12);
		end
		start <= 1;
		kind <= k;
		cell_char <= ch;
		do @(posedge clk); while (busy);
		@(negedge clk);
		burst_left--;
		words_sent++;
	endtask

	task automatic drain();
		start <= 0;
		burst_left = 0;
		while (pending != 0 || busy) @(negedge clk);
		repeat (20) @(negedge clk);
	endtask

	task automatic set_config(input logic [6:0] w, input logic [6:0] h, input logic [4:0] kc,
				  input logic [63:0] lo, input logic [63:0] hi, input logic [15:0] blank);
		logic [63:0] vals[6];
		vals = '{{57'($urandom), w}, {57'($urandom), h}, {59'($urandom), kc}, lo, hi,
			 {$urandom, 16'($urandom), blank}};
		for (int i = 0; i < 6; i++) begin
			cfg_valid <= 1;
			cfg_index <= 3'(i);
			cfg_data <= vals[i];
			do @(posedge clk); while (!cfg_ready);
			@(negedge clk);
		end
		cfg_valid <= 0;
		eff_w = (w == 0) ? 1 : (w > 64) ? 64 : w;
		eff_h = (h == 0) ? 1 : (h > 64) ? 64 : h;
		eff_keys = (kc > 16) ? 16 : kc;
		for (int i = 0; i < 8; i++) begin
			key_byte[i] = lo[i*8 +: 8];
			key_byte[i+8] = hi[i*8 +: 8];
		end
	endtask

	// load a blocky grid (cells often copy their upper or left neighbour), then fetch unless cut short
	task automatic cover_grid(input int unk_pct, input bit early_fetch, input bit cut_short);
		logic [7:0] row_ch[64];
		logic [7:0] ch, left;
		int r, cells, stop, fetches;
		cells = eff_w * eff_h;
		stop = cut_short ? $urandom_range(0, cells - 1) : cells;
		left = 0;
		put_word(KIND_START, 8'($urandom));
		if (early_fetch) put_word(KIND_FETCH, 8'($urandom));
		for (int c = 0; c < stop; c++) begin
			r = $urandom_range(99);
			if (eff_keys == 0 || $urandom_range(99) < unk_pct)
				ch = 8'($urandom);
			else if (c >= eff_w && r < 60)
				ch = row_ch[c % eff_w];
			else if (c % eff_w != 0 && r < 85)
				ch = left;
			else
				ch = key_byte[$urandom_range(eff_keys - 1)];
			row_ch[c % eff_w] = ch;
			left = ch;
			put_word(KIND_LOAD, ch);
			if ($urandom_range(99) < 2) put_word(KIND_NOP, 8'($urandom));
		end
		if (cut_short) return;
		if ($urandom_range(3) == 0)
			repeat ($urandom_range(1, 3)) put_word(KIND_LOAD, 8'($urandom));
		fetches = (cells <= 64) ? cells + 2 : 40;
		repeat (fetches) begin
			if ($urandom_range(99) < 3) put_word(KIND_NOP, 8'($urandom));
			put_word(KIND_FETCH, 8'($urandom));
		end
	endtask

	initial begin
		logic [6:0] w, h;
		logic [4:0] kc;
		logic [15:0] blank;
		repeat (10) @(negedge clk);
		arst_n = 1;
		drain();

		// no keys at all: everything is unknown
		set_config(7'd1, 7'd1, 5'd0, '0, '0, '0);
		put_word(KIND_FETCH, 8'h00);
		put_word(KIND_START, 8'hFF);
		put_word(KIND_LOAD, 8'hFF);
		put_word(KIND_LOAD, 8'h00);
		put_word(KIND_FETCH, 8'hFF);
		put_word(KIND_NOP, 8'hAA);
		put_word(KIND_START, 8'h55);
		put_word(KIND_FETCH, 8'h00);
		drain();

		// width clamps up from zero, height down from 127; keys 00, FF and 41, blank index 1
		set_config(7'd0, 7'd127, 5'd3, 64'h0000_0000_0041_FF00, '1, 16'h0002);
		put_word(KIND_START, 8'h00);
		repeat (20) put_word(KIND_LOAD, 8'h00);
		repeat (20) put_word(KIND_LOAD, 8'hFF);
		repeat (24) put_word(KIND_LOAD, 8'h41);
		repeat (4) put_word(KIND_FETCH, 8'h00);
		drain();

		// width 127 clamps to a full row; key count clamps to sixteen
		set_config(7'd127, 7'd1, 5'd31, {$urandom, $urandom}, {$urandom, $urandom}, 16'hFFFF);
		cover_grid(0, 0, 0);
		drain();
		set_config(7'd64, 7'd8, 5'd16, {$urandom, $urandom}, {$urandom, $urandom}, 16'h0000);
		cover_grid(0, 1, 0);
		drain();

		// shrink the grid after a partial load: it becomes complete
		set_config(7'd4, 7'd4, 5'd2, 64'h0000_0000_0000_3130, '0, '0);
		put_word(KIND_START, 8'h00);
		repeat (6) put_word(KIND_LOAD, 8'h30);
		drain();
		set_config(7'd2, 7'd3, 5'd2, 64'h0000_0000_0000_3130, '0, '0);
		repeat (3) put_word(KIND_FETCH, 8'h00);
		drain();

		while (words_sent < 1300) begin
			w = ($urandom_range(9) == 0) ? 7'($urandom_range(0, 127)) : 7'($urandom_range(1, 8));
			h = (w > 8) ? 7'($urandom_range(1, 4)) : 7'($urandom_range(1, 8));
			if (w <= 8 && $urandom_range(19) == 0)
				h = $urandom_range(0, 127) > 64 ? 7'd70 : 7'd0;
			kc = ($urandom_range(6) == 0) ? 5'($urandom_range(0, 31)) : 5'($urandom_range(1, 6));
			blank = ($urandom_range(1) == 0) ? 16'h0 : 16'($urandom) & 16'($urandom);
			set_config(w, h, kc, {$urandom, $urandom}, {$urandom, $urandom}, blank);
			repeat ($urandom_range(1, 3))
				cover_grid(($urandom_range(4) == 0) ? 5 : 0, $urandom_range(9) == 0,
					   $urandom_range(19) == 0);
			drain();
		end

		drain();
		repeat (100) @(negedge clk);
		if (errors == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule

[greedy_rectangle_cover_unit.f]
rtl/core/grc_pkg.sv
rtl/core/grc_ram.sv
rtl/core/grc_datapath.sv
rtl/core/grc_ctrl.sv
rtl/core/greedy_rectangle_cover_unit.sv
tb/grc_cover_checker.sv
tb/greedy_rectangle_cover_unit_tb.sv
